FILE: sv/colstat_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Column statistics package
// Shared widths, value limits, the column summary type and queue sizing.
// ----------------------------------------------------------------------------
package colstat_pkg;

  localparam int VAL_W       = 11;
  localparam int IDX_W       = 11;
  localparam int MAP_SIZE    = 1099;
  localparam int DIST_W      = 11;
  localparam int EPOCH_W     = 8;
  localparam int QUEUE_DEPTH = 2;
  localparam int PTR_W       = 1;
  localparam int LEVEL_W     = 2;

  localparam int IN_DATA_W   = 16;
  localparam int OUT_SUM_W   = 23;
  localparam int OUT_CNT_W   = 13;
  localparam int OUT_AVG_W   = 19;
  localparam int OUT_DATA_W  = 88;
  localparam int OUT_USER_W  = 2;

  typedef logic signed [VAL_W-1:0] value_t;

  localparam value_t VAL_LOW_C  = -11'sd99;
  localparam value_t VAL_HIGH_C = 11'sd999;

  localparam logic [EPOCH_W-1:0] EPOCH_FIRST = EPOCH_W'(1);
  localparam logic [EPOCH_W-1:0] EPOCH_LAST  = '1;

  // Per-column results that need no further arithmetic in the back end.
  typedef struct packed {
    value_t              max_value;
    value_t              min_value;
    logic [DIST_W-1:0]   distinct;
    logic                overflowed;
  } colstat_t;

endpackage

FILE: sv/column_statistics_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Column statistics top level
// Sum, count, average, extremes and distinct count over one table column.
// ----------------------------------------------------------------------------
// The block takes one column value per clock cycle while in_tready is high;
// a transaction with tlast high closes the column, and one result transaction
// follows for it. After the last value a column summary waits in a two-entry
// queue while an iterative divider forms the average one quotient bit per
// cycle. The dividend has the sum width less one plus FRAC_BITS bits (31 at
// the default parameters). The divider takes a new column only after it has
// finished the previous one, so short columns are limited by it. The presence
// map for the distinct count is a 1099-entry memory tagged with a column
// epoch: after reset, and again after every 255th column, a clearing pass
// over all 1099 entries runs during which in_tready stays low.
module column_statistics_top import colstat_pkg::*; #(
  parameter int ROWS_MAX  = 4096,
  parameter int FRAC_BITS = 8
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [IN_DATA_W-1:0]  in_tdata,   // [10:0] sample_value, rest zero
  input  logic                  in_tuser,   // [0] is_missing
  input  logic                  in_tlast,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  // [22:0] total_sum, [35:23] present_count, [54:36] average_q8,
  // [65:55] max_value, [76:66] min_value, [87:77] distinct_count
  output logic [OUT_DATA_W-1:0] out_tdata,
  output logic [OUT_USER_W-1:0] out_tuser   // [0] empty_set, [1] overflowed
);

  localparam int CNT_W = $clog2(ROWS_MAX + 1);
  localparam int SUM_W = CNT_W + VAL_W;
  localparam int QW    = SUM_W + CNT_W + $bits(colstat_t);

  logic                    q_push, q_pop;
  logic [LEVEL_W-1:0]      q_level;
  logic signed [SUM_W-1:0] f_sum;
  logic [CNT_W-1:0]        f_count;
  colstat_t                f_stats;
  logic [QW-1:0]           q_in, q_out;
  logic signed [SUM_W-1:0] b_sum;
  logic [CNT_W-1:0]        b_count;
  colstat_t                b_stats;

  colstat_front #(.ROWS_MAX(ROWS_MAX)) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_tvalid),
    .in_ready   (in_tready),
    .in_value   (in_tdata[VAL_W-1:0]),
    .in_missing (in_tuser),
    .in_last    (in_tlast),
    .q_level    (q_level),
    .q_push     (q_push),
    .q_sum      (f_sum),
    .q_count    (f_count),
    .q_stats    (f_stats)
  );

  assign q_in = {f_sum, f_count, f_stats};

  colstat_queue #(.WIDTH(QW)) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_in),
    .pop       (q_pop),
    .pop_data  (q_out),
    .level     (q_level)
  );

  assign {b_sum, b_count, b_stats} = q_out;

  colstat_back #(.ROWS_MAX(ROWS_MAX), .FRAC_BITS(FRAC_BITS)) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_level    (q_level),
    .q_pop      (q_pop),
    .q_sum      (b_sum),
    .q_count    (b_count),
    .q_stats    (b_stats),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

endmodule

FILE: sv/colstat_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Column statistics front end
// Accepts column values, clamps them, and keeps sum, count, extremes and the
// distinct count; pushes one summary per column into the queue.
// ----------------------------------------------------------------------------
module colstat_front import colstat_pkg::*; #(
  parameter int ROWS_MAX = 4096,
  localparam int CNT_W = $clog2(ROWS_MAX + 1),
  localparam int SUM_W = CNT_W + VAL_W
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  value_t                  in_value,
  input  logic                    in_missing,
  input  logic                    in_last,
  input  logic [LEVEL_W-1:0]      q_level,
  output logic                    q_push,
  output logic signed [SUM_W-1:0] q_sum,
  output logic [CNT_W-1:0]        q_count,
  output colstat_t                q_stats
);

  // Presence map: each entry holds the epoch of the column that last saw it.
  logic [EPOCH_W-1:0] map_mem [MAP_SIZE];
  logic [EPOCH_W-1:0] rd_epoch_r;

  logic               accept;
  value_t             v_sat;
  logic [IDX_W-1:0]   rd_idx;

  logic               s1_valid_r;
  value_t             s1_val_r;
  logic [IDX_W-1:0]   s1_idx_r;
  logic               s1_miss_r;
  logic               s1_last_r;

  logic               fw_valid_r, fw_valid_nxt;
  logic [IDX_W-1:0]   fw_idx_r;

  logic signed [SUM_W-1:0] sum_r, sum_nxt;
  logic [CNT_W-1:0]        count_r, count_nxt;
  value_t                  max_r, max_nxt;
  value_t                  min_r, min_nxt;
  logic [DIST_W-1:0]       dist_r, dist_nxt;
  logic                    ovf_r, ovf_nxt;
  logic [EPOCH_W-1:0]      epoch_r;

  logic               clr_active_r;
  logic [IDX_W-1:0]   clr_cnt_r;

  logic               in_cap, take, seen, new_val, col_end, wrap_hold;
  logic [LEVEL_W:0]   need;
  logic               wr_en;
  logic [IDX_W-1:0]   wr_addr;
  logic [EPOCH_W-1:0] wr_data;

  always_comb begin
    if (in_value < VAL_LOW_C) begin
      v_sat = VAL_LOW_C;
    end else if (in_value > VAL_HIGH_C) begin
      v_sat = VAL_HIGH_C;
    end else begin
      v_sat = in_value;
    end
  end

  assign rd_idx = IDX_W'(v_sat - VAL_LOW_C);

  assign col_end   = s1_valid_r && s1_last_r;
  assign wrap_hold = col_end && (epoch_r == EPOCH_LAST);
  // Room is reserved for a summary from any accepted transaction, so the
  // stage behind the memory read never has to stall.
  assign need      = {1'b0, q_level} + (LEVEL_W+1)'(col_end);
  assign in_ready  = !clr_active_r && !wrap_hold && (need < (LEVEL_W+1)'(QUEUE_DEPTH));
  assign accept    = in_valid && in_ready;

  assign in_cap  = count_r < CNT_W'(ROWS_MAX);
  assign take    = s1_valid_r && !s1_miss_r && in_cap;
  // The read issued alongside the previous write sees stale data; forward it.
  assign seen    = (rd_epoch_r == epoch_r) || (fw_valid_r && (fw_idx_r == s1_idx_r));
  assign new_val = take && !seen;

  always_comb begin
    sum_nxt   = take ? sum_r + SUM_W'(s1_val_r) : sum_r;
    count_nxt = take ? count_r + 1'b1 : count_r;
    max_nxt   = (take && (s1_val_r > max_r)) ? s1_val_r : max_r;
    min_nxt   = (take && (s1_val_r < min_r)) ? s1_val_r : min_r;
    dist_nxt  = new_val ? dist_r + 1'b1 : dist_r;
    ovf_nxt   = ovf_r || (s1_valid_r && !s1_miss_r && !in_cap);
    fw_valid_nxt = new_val && !s1_last_r;
  end

  assign q_push  = col_end;
  assign q_sum   = sum_nxt;
  assign q_count = count_nxt;
  assign q_stats = '{max_value: max_nxt, min_value: min_nxt,
                     distinct: dist_nxt, overflowed: ovf_nxt};

  assign wr_en   = clr_active_r || new_val;
  assign wr_addr = clr_active_r ? clr_cnt_r : s1_idx_r;
  assign wr_data = clr_active_r ? '0 : epoch_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      map_mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      rd_epoch_r <= map_mem[rd_idx];
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_val_r  <= v_sat;
      s1_idx_r  <= rd_idx;
      s1_miss_r <= in_missing;
      s1_last_r <= in_last;
    end
    fw_idx_r <= s1_idx_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r   <= 1'b0;
      fw_valid_r   <= 1'b0;
      sum_r        <= '0;
      count_r      <= '0;
      max_r        <= VAL_LOW_C;
      min_r        <= VAL_HIGH_C;
      dist_r       <= '0;
      ovf_r        <= 1'b0;
      epoch_r      <= EPOCH_FIRST;
      clr_active_r <= 1'b1;
      clr_cnt_r    <= '0;
    end else begin
      s1_valid_r <= accept;
      fw_valid_r <= fw_valid_nxt;
      if (col_end) begin
        sum_r   <= '0;
        count_r <= '0;
        max_r   <= VAL_LOW_C;
        min_r   <= VAL_HIGH_C;
        dist_r  <= '0;
        ovf_r   <= 1'b0;
        if (epoch_r == EPOCH_LAST) begin
          epoch_r      <= EPOCH_FIRST;
          clr_active_r <= 1'b1;
          clr_cnt_r    <= '0;
        end else begin
          epoch_r <= epoch_r + 1'b1;
        end
      end else begin
        sum_r   <= sum_nxt;
        count_r <= count_nxt;
        max_r   <= max_nxt;
        min_r   <= min_nxt;
        dist_r  <= dist_nxt;
        ovf_r   <= ovf_nxt;
      end
      if (clr_active_r) begin
        clr_cnt_r <= clr_cnt_r + 1'b1;
        if (clr_cnt_r == IDX_W'(MAP_SIZE - 1)) begin
          clr_active_r <= 1'b0;
        end
      end
    end
  end

  a_dist_le_count: assert property (@(posedge clk) disable iff (!rst_n)
    CNT_W'(dist_r) <= count_r || CNT_W < DIST_W)
    else $error("distinct count exceeds present count");

  a_max_ge_min: assert property (@(posedge clk) disable iff (!rst_n)
    (count_r != '0) |-> (max_r >= min_r))
    else $error("running maximum below running minimum");

  a_no_item_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
    clr_active_r |=> !s1_valid_r || !$past(clr_active_r) || $past(s1_valid_r) == 1'b0)
    else $error("item entered during presence map clearing");

endmodule

FILE: sv/colstat_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Column statistics summary queue
// Short first-in first-out buffer of column summaries between front and back.
// ----------------------------------------------------------------------------
module colstat_queue import colstat_pkg::*; #(
  parameter int WIDTH = 8
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  logic [WIDTH-1:0]   push_data,
  input  logic               pop,
  output logic [WIDTH-1:0]   pop_data,
  output logic [LEVEL_W-1:0] level
);

  logic [WIDTH-1:0]   slot_r [QUEUE_DEPTH];
  logic [PTR_W-1:0]   wr_ptr_r, rd_ptr_r;
  logic [LEVEL_W-1:0] level_r;

  assign level    = level_r;
  assign pop_data = slot_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      level_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      if (push && !pop) begin
        level_r <= level_r + 1'b1;
      end else if (pop && !push) begin
        level_r <= level_r - 1'b1;
      end
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> (level_r != LEVEL_W'(QUEUE_DEPTH)))
    else $error("summary pushed into a full queue");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> (level_r != '0))
    else $error("summary popped from an empty queue");

endmodule

FILE: sv/colstat_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Column statistics back end
// Divides sum by count one quotient bit per cycle and holds the result.
// ----------------------------------------------------------------------------
module colstat_back import colstat_pkg::*; #(
  parameter int ROWS_MAX  = 4096,
  parameter int FRAC_BITS = 8,
  localparam int CNT_W = $clog2(ROWS_MAX + 1),
  localparam int SUM_W = CNT_W + VAL_W
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic [LEVEL_W-1:0]      q_level,
  output logic                    q_pop,
  input  logic signed [SUM_W-1:0] q_sum,
  input  logic [CNT_W-1:0]        q_count,
  input  colstat_t                q_stats,
  output logic                    out_tvalid,
  input  logic                    out_tready,
  output logic [OUT_DATA_W-1:0]   out_tdata,
  output logic [OUT_USER_W-1:0]   out_tuser
);

  localparam int DVD_W = SUM_W - 1 + FRAC_BITS;
  localparam int BIT_W = $clog2(DVD_W + 1);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_DIV  = 2'd1;
  localparam logic [1:0] S_DONE = 2'd2;

  logic [1:0]              state_r;
  logic signed [SUM_W-1:0] sum_r;
  logic [CNT_W-1:0]        cnt_r;
  colstat_t                stats_r;
  logic                    neg_r;
  logic [DVD_W-1:0]        dvd_r;
  logic [CNT_W-1:0]        rem_r;
  logic [DVD_W-1:0]        quo_r;
  logic [BIT_W-1:0]        bit_r;

  logic                    out_valid_r;
  logic [OUT_DATA_W-1:0]   out_data_r;
  logic [OUT_USER_W-1:0]   out_user_r;

  logic [SUM_W-1:0]        mag;
  logic [CNT_W:0]          rem_sh;
  logic                    ge;
  logic                    load;
  logic signed [DVD_W:0]   avg_full;
  logic [OUT_AVG_W-1:0]    avg_out;

  assign q_pop = (state_r == S_IDLE) && (q_level != '0);
  assign mag   = q_sum[SUM_W-1] ? SUM_W'(-q_sum) : SUM_W'(q_sum);

  assign rem_sh = {rem_r, dvd_r[DVD_W-1]};
  assign ge     = rem_sh >= {1'b0, cnt_r};

  assign load     = (state_r == S_DONE) && (!out_valid_r || out_tready);
  assign avg_full = neg_r ? -$signed({1'b0, quo_r}) : $signed({1'b0, quo_r});
  assign avg_out  = OUT_AVG_W'(avg_full);

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;

  always_ff @(posedge clk) begin
    case (state_r)
      S_IDLE: begin
        if (q_pop) begin
          sum_r   <= q_sum;
          cnt_r   <= q_count;
          stats_r <= q_stats;
          neg_r   <= q_sum[SUM_W-1];
          dvd_r   <= DVD_W'(mag) << FRAC_BITS;
          rem_r   <= '0;
          quo_r   <= '0;
          bit_r   <= '0;
        end
      end
      S_DIV: begin
        rem_r <= ge ? CNT_W'(rem_sh - {1'b0, cnt_r}) : rem_sh[CNT_W-1:0];
        quo_r <= {quo_r[DVD_W-2:0], ge};
        dvd_r <= dvd_r << 1;
        bit_r <= bit_r + 1'b1;
      end
      default: begin
      end
    endcase
    if (load) begin
      out_data_r <= {stats_r.distinct, stats_r.min_value, stats_r.max_value, avg_out,
                     OUT_CNT_W'(cnt_r), OUT_SUM_W'(sum_r)};
      out_user_r <= {stats_r.overflowed, (cnt_r == '0)};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      case (state_r)
        S_IDLE: begin
          if (q_pop) begin
            state_r <= (q_count == '0) ? S_DONE : S_DIV;
          end
        end
        S_DIV: begin
          if (bit_r == BIT_W'(DVD_W - 1)) begin
            state_r <= S_DONE;
          end
        end
        S_DONE: begin
          if (load) begin
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
      if (load) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  a_div_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DIV) |-> (cnt_r != '0))
    else $error("division started with zero count");

  a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DIV) |-> (rem_r < cnt_r))
    else $error("partial remainder not below divisor");

  a_empty_zero_avg: assert property (@(posedge clk) disable iff (!rst_n)
    (load && (cnt_r == '0)) |=> (out_tdata[OUT_SUM_W+OUT_CNT_W +: OUT_AVG_W] == '0))
    else $error("empty column gave a nonzero average");

endmodule

FILE: dv/column_statistics_top_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Column statistics testbench
// Streams table columns into the block with random gaps and output stalls,
// predicts each column summary (sum, count, Q8 average, extremes, distinct
// count, empty and overflow flags) and checks every result transaction.
// ----------------------------------------------------------------------------
module column_statistics_top_test;
  import colstat_pkg::*;

  localparam int ROWS_LIMIT  = 4096;
  localparam int FRAC        = 8;
  localparam int STALL_LIMIT = 5000;
  localparam int RANDOM_ITEMS = 830;

  typedef struct {
    logic [OUT_SUM_W-1:0] sum;
    logic [OUT_CNT_W-1:0] cnt;
    logic [OUT_AVG_W-1:0] avg;
    logic [VAL_W-1:0]     max_v;
    logic [VAL_W-1:0]     min_v;
    logic [DIST_W-1:0]    n_distinct;
    logic                 empty;
    logic                 ovf;
  } column_summary_t;

  // Predicts one summary per closed column and checks results in order.
  class stats_scoreboard;
    longint          acc_sum;
    int              acc_cnt;
    int              acc_hi;
    int              acc_lo;
    bit              value_seen[MAP_SIZE];
    int              acc_distinct;
    bit              acc_ovf;
    column_summary_t summaries_due[$];
    int              errors;

    function new();
      errors = 0;
      clear_column();
    endfunction

    function void clear_column();
      acc_sum = 0;
      acc_cnt = 0;
      acc_hi  = -99;
      acc_lo  = 999;
      foreach (value_seen[i]) value_seen[i] = 1'b0;
      acc_distinct = 0;
      acc_ovf = 1'b0;
    endfunction

    function void note_sample(logic [VAL_W-1:0] raw, logic missing, logic last);
      int              v;
      longint          mag;
      longint          quo;
      column_summary_t s;
      v = $signed(raw);
      if (v < -99) v = -99;
      if (v > 999) v = 999;
      if (!missing) begin
        if (acc_cnt >= ROWS_LIMIT) begin
          acc_ovf = 1'b1;
        end else begin
          acc_sum += v;
          acc_cnt++;
          if (v > acc_hi) acc_hi = v;
          if (v < acc_lo) acc_lo = v;
          if (!value_seen[v + 99]) begin
            value_seen[v + 99] = 1'b1;
            acc_distinct++;
          end
        end
      end
      if (!last) return;
      // Average is truncated toward zero, so divide the magnitude.
      quo = 0;
      if (acc_cnt != 0) begin
        mag = (acc_sum < 0) ? -acc_sum : acc_sum;
        quo = (mag << FRAC) / acc_cnt;
        if (acc_sum < 0) quo = -quo;
      end
      s.sum        = acc_sum[OUT_SUM_W-1:0];
      s.cnt        = acc_cnt[OUT_CNT_W-1:0];
      s.avg        = quo[OUT_AVG_W-1:0];
      s.max_v      = acc_hi[VAL_W-1:0];
      s.min_v      = acc_lo[VAL_W-1:0];
      s.n_distinct = acc_distinct[DIST_W-1:0];
      s.empty      = (acc_cnt == 0);
      s.ovf        = acc_ovf;
      summaries_due.insert(summaries_due.size(), s);
      clear_column();
    endfunction

    function void compare_field(string fname, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
        $display("%0t: %s mismatch: expected 0x%0h, actual 0x%0h", $time, fname, want, got);
        errors++;
      end
    endfunction

    function void check_summary(logic [OUT_DATA_W-1:0] data, logic [OUT_USER_W-1:0] user);
      column_summary_t s;
      if (summaries_due.size() == 0) begin
        $display("%0t: unexpected result transaction: expected none, actual data 0x%0h user 0x%0h",
                 $time, data, user);
        errors++;
        return;
      end
      s = summaries_due.pop_front();
      compare_field("total_sum",      s.sum,        data[22:0]);
      compare_field("present_count",  s.cnt,        data[35:23]);
      compare_field("average_q8",     s.avg,        data[54:36]);
      compare_field("max_value",      s.max_v,      data[65:55]);
      compare_field("min_value",      s.min_v,      data[76:66]);
      compare_field("distinct_count", s.n_distinct, data[87:77]);
      compare_field("empty_set",      s.empty,      user[0]);
      compare_field("overflowed",     s.ovf,        user[1]);
    endfunction
  endclass

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata = '0;
  logic                  in_tuser = 1'b0;
  logic                  in_tlast = 1'b0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic [OUT_USER_W-1:0] out_tuser;

  stats_scoreboard sb = new();
  bit sender_gaps = 1'b1;
  int random_items = 0;
  int idle_cycles = 0;
  int value_pool[4];

  always #5 clk = ~clk;

  column_statistics_top #(
    .ROWS_MAX  (ROWS_LIMIT),
    .FRAC_BITS (FRAC)
  ) u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  // Ends the run if neither side completes a transaction for too long.
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("column_statistics_top_test: FAIL");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic send_sample(input logic [VAL_W-1:0] raw, input logic missing,
                             input logic last);
    int gap;
    gap = sender_gaps ? $urandom_range(0, 19) : 0;
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {{(IN_DATA_W-VAL_W){1'b0}}, raw};
    in_tuser  <= missing;
    in_tlast  <= last;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    sb.note_sample(raw, missing, last);
  endtask

  task automatic pause_until_drained();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (sb.summaries_due.size() != 0);
  endtask

  function automatic logic [VAL_W-1:0] pick_value(int style);
    int r;
    r = $urandom_range(0, 99);
    if (r < 6) return VAL_W'($urandom());
    if (r < 12) return ($urandom_range(0, 1) != 0) ? VAL_HIGH_C : VAL_LOW_C;
    if (style == 0) return VAL_W'(value_pool[$urandom_range(0, 3)]);
    if (style == 1) return VAL_W'(-$urandom_range(0, 99));
    return VAL_W'(int'($urandom_range(0, 1098)) - 99);
  endfunction

  task automatic send_column(input int len, input int style, input int miss_pct);
    foreach (value_pool[i]) value_pool[i] = int'($urandom_range(0, 1098)) - 99;
    for (int i = 0; i < len; i++) begin
      send_sample(pick_value(style), $urandom_range(0, 99) < miss_pct, i == len - 1);
      if (style != 3 || i != len - 1) random_items++;
    end
  endtask

  // Result side: random stalls, with whole stretches of none.
  initial begin
    int  gap;
    int  taken;
    bit  stalls_on;
    taken = 0;
    stalls_on = 1'b1;
    wait (rst_n === 1'b1);
    forever begin
      if (taken % 32 == 0) stalls_on = ($urandom_range(0, 3) != 0);
      gap = stalls_on ? $urandom_range(0, 19) : 0;
      if (gap > 0) begin
        out_tready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_tready <= 1'b1;
      @(posedge clk);
      while (!out_tvalid) @(posedge clk);
      sb.check_summary(out_tdata, out_tuser);
      taken++;
    end
  end

  initial begin
    int len;
    int r;
    int miss_pct;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // Directed columns: single extremes, an all-missing column, duplicates,
    // saturation of out-of-range values and rounding of signed averages.
    send_sample(VAL_LOW_C, 1'b0, 1'b1);
    send_sample(VAL_HIGH_C, 1'b0, 1'b1);
    send_sample(11'h7ff, 1'b1, 1'b0);
    send_sample(11'h2aa, 1'b1, 1'b1);
    send_sample(11'd5, 1'b0, 1'b0);
    send_sample(11'h555, 1'b1, 1'b0);
    send_sample(VAL_W'(-7), 1'b0, 1'b0);
    send_sample(11'd5, 1'b0, 1'b0);
    send_sample(11'd0, 1'b1, 1'b1);
    send_sample(VAL_W'(-100), 1'b0, 1'b0);
    send_sample(11'd1000, 1'b0, 1'b0);
    send_sample(11'h400, 1'b0, 1'b0);
    send_sample(11'h3ff, 1'b0, 1'b1);
    send_sample(VAL_W'(-1), 1'b0, 1'b0);
    send_sample(VAL_W'(-1), 1'b0, 1'b0);
    send_sample(11'd0, 1'b0, 1'b1);
    send_sample(11'd1, 1'b0, 1'b0);
    send_sample(11'd1, 1'b0, 1'b0);
    send_sample(11'd0, 1'b0, 1'b1);
    send_sample(11'd0, 1'b0, 1'b1);
    pause_until_drained();

    // Random columns, mostly very short so that the epoch of the presence
    // map wraps and the clearing pass runs again.
    while (random_items < RANDOM_ITEMS) begin
      sender_gaps = ($urandom_range(0, 3) != 0);
      r = $urandom_range(0, 99);
      if (r < 92) len = $urandom_range(1, 2);
      else if (r < 99) len = $urandom_range(3, 24);
      else len = $urandom_range(25, 80);
      r = $urandom_range(0, 99);
      if (r < 50) miss_pct = 0;
      else if (r < 80) miss_pct = 10;
      else if (r < 95) miss_pct = 50;
      else miss_pct = 100;
      send_column(len, $urandom_range(0, 2), miss_pct);
    end

    pause_until_drained();
    repeat (60) @(posedge clk);
    if (sb.errors == 0) begin
      $display("column_statistics_top_test: PASS");
    end else begin
      $display("column_statistics_top_test: FAIL");
    end
    $finish;
  end

endmodule
